[rtl/longest_increasing_subsequence_top_macros.svh]
// Assertion helpers for the subsequence block.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_TOP_MACROS_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define LIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define LIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lis_pkg.sv]
`timescale 1ns / 1ps

package lis_pkg;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int VAL_OUT_W   = 32;
    localparam int POS_W       = 6;
    localparam int LEN_W       = 7;
    localparam int PRED_W      = 7;

    // Result tdata layout, lowest bit first
    localparam int OUT_VAL_LSB = 0;
    localparam int OUT_POS_LSB = OUT_VAL_LSB + VAL_OUT_W;
    localparam int OUT_LEN_LSB = OUT_POS_LSB + POS_W;
    localparam int OUT_OVF_BIT = OUT_LEN_LSB + LEN_W;
    localparam int OUT_USED_W  = OUT_OVF_BIT + 1;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Predecessor code for the first element of a run
    localparam logic [PRED_W-1:0] NO_PRED = 7'd127;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // take a new value, start search
        logic drop;         // item arrived at capacity
        logic step;         // one binary search step
        logic update;       // write tail, link and stored value
        logic trace_start;  // start traceback from longest run
        logic walk;         // one traceback step
        logic emit;         // load one result into output register
        logic clear;        // end of run, reset counters
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic lo_lt_hi;
        logic is_final;
        logic best_zero;
        logic walk_last;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

[rtl/lis_ctrl.sv]
`timescale 1ns / 1ps

module lis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  lis_pkg::t_status i_status,
    output logic             o_in_ready,
    output lis_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_SEARCH    = 7'b0000010,
        S_TRACE     = 7'b0000100,
        S_WALK      = 7'b0001000,
        S_EMIT_PATH = 7'b0010000,
        S_EMIT_VAL  = 7'b0100000,
        S_EMIT_LOAD = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.full) begin
                        o_cmd.drop = 1'b1;
                        n_state    = i_in_last ? S_TRACE : S_IDLE;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (i_status.lo_lt_hi) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state      = i_status.is_final ? S_TRACE : S_IDLE;
                end
            end
            S_TRACE: begin
                o_cmd.trace_start = 1'b1;
                if (i_status.best_zero) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_last) begin
                    n_state = S_EMIT_PATH;
                end
            end
            S_EMIT_PATH: begin
                n_state = S_EMIT_VAL;
            end
            S_EMIT_VAL: begin
                n_state = S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_EMIT_PATH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/lis_datapath.sv]
`timescale 1ns / 1ps

module lis_datapath #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lis_pkg::t_cmd                      i_cmd,
    input  logic [lis_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic                               i_in_last,
    input  logic                               i_out_ready,
    output lis_pkg::t_status                   o_status,
    output logic                               o_out_valid,
    output logic [lis_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                               o_out_last
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    // Storage, one write and one registered read port each
    logic [VALUE_BITS-1:0]          stored_mem [MAX_ITEMS];
    logic [VALUE_BITS-1:0]          tail_mem   [MAX_ITEMS];
    logic [AW-1:0]                  tpos_mem   [MAX_ITEMS];
    logic [lis_pkg::PRED_W-1:0]     pred_mem   [MAX_ITEMS];
    logic [AW-1:0]                  path_mem   [MAX_ITEMS];

    logic [VALUE_BITS-1:0]          stored_rdata;
    logic [VALUE_BITS-1:0]          tail_rdata;
    logic [AW-1:0]                  tpos_rdata;
    logic [lis_pkg::PRED_W-1:0]     pred_rdata;
    logic [AW-1:0]                  path_rdata;

    // Control and working registers
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_final;
    logic [CW-1:0]         r_lo;
    logic [CW-1:0]         n_lo;
    logic [CW-1:0]         r_hi;
    logic [CW-1:0]         n_hi;
    logic [CW-1:0]         r_best;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_k;
    logic                  r_first;
    logic                  r_dropped;

    // Output register
    logic                            r_out_valid;
    logic [lis_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                            r_out_last;

    logic [CW:0]           w_sum;
    logic [CW-1:0]         w_mid;
    logic [CW:0]           w_nsum;
    logic [AW-1:0]         w_tail_raddr;
    logic [CW-1:0]         w_tpos_idx;
    logic [AW-1:0]         w_p;
    logic [CW-1:0]         w_k_dec;
    logic [CW-1:0]         w_k_inc;
    logic                  w_less;

    // Binary search bounds
    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid  = w_sum[CW:1];
    assign w_less = $signed(tail_rdata) < $signed(r_value);

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.load) begin
            n_lo = '0;
            n_hi = r_best;
        end else if (i_cmd.step) begin
            if (w_less) begin
                n_lo = CW'(w_mid + CW'(1));
            end else begin
                n_hi = w_mid;
            end
        end
    end

    // Read addresses follow the next bounds so data is ready next cycle
    assign w_nsum       = {1'b0, n_lo} + {1'b0, n_hi};
    assign w_tail_raddr = w_nsum[AW:1];
    assign w_tpos_idx   = i_cmd.trace_start ? CW'(r_best - CW'(1)) : CW'(n_lo - CW'(1));

    // Traceback pointer: first from the tail, then through the links
    always_comb begin
        if (r_first) begin
            w_p = tpos_rdata;
        end else if (pred_rdata == lis_pkg::NO_PRED) begin
            w_p = '0;
        end else begin
            w_p = pred_rdata[AW-1:0];
        end
    end

    assign w_k_dec = CW'(r_k - CW'(1));
    assign w_k_inc = CW'(r_k + CW'(1));

    // stored values
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            stored_mem[r_count[AW-1:0]] <= r_value;
        end
    end
    always_ff @(posedge i_clk) begin
        stored_rdata <= stored_mem[path_rdata];
    end

    // tail values
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            tail_mem[r_lo[AW-1:0]] <= r_value;
        end
    end
    always_ff @(posedge i_clk) begin
        tail_rdata <= tail_mem[w_tail_raddr];
    end

    // tail positions
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            tpos_mem[r_lo[AW-1:0]] <= r_count[AW-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        tpos_rdata <= tpos_mem[w_tpos_idx[AW-1:0]];
    end

    // predecessor links
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            pred_mem[r_count[AW-1:0]] <= (r_lo != '0) ? lis_pkg::PRED_W'(tpos_rdata)
                                                      : lis_pkg::NO_PRED;
        end
    end
    always_ff @(posedge i_clk) begin
        pred_rdata <= pred_mem[w_p];
    end

    // traceback path
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            path_mem[w_k_dec[AW-1:0]] <= w_p;
        end
    end
    always_ff @(posedge i_clk) begin
        path_rdata <= path_mem[r_k[AW-1:0]];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (i_cmd.load) begin
            r_value <= i_in_data[VALUE_BITS-1:0];
            r_final <= i_in_last;
        end
        if (i_cmd.trace_start) begin
            r_k <= r_best;
        end else if (i_cmd.walk) begin
            r_k <= w_k_dec;
        end else if (i_cmd.emit) begin
            r_k <= w_k_inc;
        end
        if (i_cmd.trace_start) begin
            r_first <= 1'b1;
        end else if (i_cmd.walk) begin
            r_first <= 1'b0;
        end
    end

    // Run counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best    <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.clear) begin
            r_best    <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (i_cmd.drop) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.update) begin
                r_count <= CW'(r_count + CW'(1));
                if (r_lo == r_best) begin
                    r_best <= CW'(r_best + CW'(1));
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload: value, position, length, overflow, zero pad
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= lis_pkg::OUT_TDATA_W'({
                r_dropped,
                lis_pkg::LEN_W'(r_best),
                lis_pkg::POS_W'(path_rdata),
                lis_pkg::VAL_OUT_W'($signed(stored_rdata))
            });
            r_out_last <= (w_k_inc == r_best);
        end
    end

    // Status
    assign o_status.full      = (r_count == CW'(MAX_ITEMS));
    assign o_status.lo_lt_hi  = (r_lo < r_hi);
    assign o_status.is_final  = r_final;
    assign o_status.best_zero = (r_best == '0);
    assign o_status.walk_last = (r_k == CW'(1));
    assign o_status.emit_last = (w_k_inc == r_best);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

[rtl/longest_increasing_subsequence_top.sv]
// Longest strictly increasing subsequence finder. Send a sequence of signed
// values, one per transfer, with tlast on the final one; only the low
// VALUE_BITS bits of each value count. At most MAX_ITEMS values are kept,
// further ones are dropped and the overflow bit is set in every result. After
// the final value the block sends the subsequence in input order, one transfer
// per element, with tlast on its last element, then starts a new sequence.
// Timing: a stored value is taken, then makes S binary search steps over the
// current run length L, at most ceil(log2(L + 1)), and is then written; L is
// at most MAX_ITEMS - 1 when a value is stored. A value dropped at capacity
// is taken without a search. The binary search makes one compare per cycle
// against the registered read of the tail memory. After the final value the
// traceback starts at the end of the longest run and walks back through the
// links, one predecessor memory read per cycle; each result then passes a
// path read, a value read and an output load held back by downstream stalls.
// Input is not accepted during traceback and result output; the last result
// waiting in the output register does not block the next input transfer.
`timescale 1ns / 1ps
`include "longest_increasing_subsequence_top_macros.svh"

module longest_increasing_subsequence_top #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] sample_value
    input  logic [lis_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // final_item
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] elem_value, [37:32] elem_position, [44:38] seq_length,
    // [45] overflow_flag, [47:46] zero
    output logic [lis_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // end_of_run
    output logic                                o_m_axis_tlast
);

    lis_pkg::t_cmd    w_cmd;
    lis_pkg::t_status w_status;

    lis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    lis_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_s_axis_tdata),
        .i_in_last   (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

    // A search step only runs while the bounds are still open
    `LIS_ASSERT_NOW(a_step_open, i_clk, i_rst_n,
                    w_cmd.step, w_status.lo_lt_hi, "search step on closed bounds")

    // The table is written only once the search has closed
    `LIS_ASSERT_NOW(a_update_closed, i_clk, i_rst_n,
                    w_cmd.update, !w_status.lo_lt_hi, "update before search closed")

    // A loaded result is presented on the next cycle
    `LIS_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n,
                     w_cmd.emit, o_m_axis_tvalid, "emitted result not valid")

    // Every result reports a nonzero subsequence length
    `LIS_ASSERT_NOW(a_len_nonzero, i_clk, i_rst_n,
                    o_m_axis_tvalid, o_m_axis_tdata[44:38] != 7'd0, "zero length in result")

endmodule

[tb/longest_increasing_subsequence_top_tb.sv]
`timescale 1ns / 1ps

module longest_increasing_subsequence_top_tb;

    localparam int DEPTH        = 64;
    localparam int RAND_ITEMS   = 290;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;
    localparam int DIR_ROWS     = 23;

    // One emitted subsequence element
    typedef struct packed {
        logic [31:0]               value;
        logic [lis_pkg::POS_W-1:0] pos;
        logic [lis_pkg::LEN_W-1:0] len;
        logic                      ovf;
        logic                      eor;
    } t_elem;

    // Directed row: sample, final mark, and a typed expectation where obvious
    typedef struct packed {
        logic [31:0] sample;
        logic        fin;
        logic        typed;
        t_elem       want;
    } t_dir_row;

    // Value patterns for the random sequences
    typedef enum int {
        PAT_WIDE,
        PAT_NARROW,
        PAT_RISING,
        PAT_EXTREME
    } t_value_pat;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_valid;
    logic [lis_pkg::IN_TDATA_W-1:0] s_data;
    logic s_last;
    logic m_ready;

    logic s_ready;
    logic m_valid;
    logic [lis_pkg::OUT_TDATA_W-1:0] m_data;
    logic m_last;

    // Source and sink idle rates, percent of cycles
    int src_idle_pct;
    int dst_idle_pct;

    int err_count;
    int cycle_count;
    int items_sent;
    int elems_seen;
    int runs_sent;
    int spill_runs;

    // Predictor state
    logic signed [31:0]         seen_vals [DEPTH];
    logic signed [31:0]         tail_vals [DEPTH];
    logic [lis_pkg::POS_W-1:0]  tail_idx  [DEPTH];
    logic [lis_pkg::PRED_W-1:0] back_link [DEPTH];
    logic [lis_pkg::POS_W-1:0]  trace_path[DEPTH];
    int run_len;
    int n_seen;
    logic spilled;

    t_elem pending_elems[$];

    t_dir_row dir_rows [DIR_ROWS] = '{
        // single-item runs at the extremes
        '{32'h7FFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFF, 6'd0, 7'd1, 1'b0, 1'b1}},
        '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 6'd0, 7'd1, 1'b0, 1'b1}},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 6'd0, 7'd1, 1'b0, 1'b1}},
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 6'd0, 7'd1, 1'b0, 1'b1}},
        // min, -1, 0, max: full-range increasing run
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, '0},
        // equal values replace the tail
        '{32'd5, 1'b0, 1'b0, '0},
        '{32'd5, 1'b0, 1'b0, '0},
        '{32'd5, 1'b1, 1'b0, '0},
        // strictly decreasing
        '{32'd3, 1'b0, 1'b0, '0},
        '{32'd2, 1'b0, 1'b0, '0},
        '{32'd1, 1'b1, 1'b0, '0},
        // interleaved run with tail replacements
        '{32'd1, 1'b0, 1'b0, '0},
        '{32'd5, 1'b0, 1'b0, '0},
        '{32'd2, 1'b0, 1'b0, '0},
        '{32'd6, 1'b0, 1'b0, '0},
        '{32'd3, 1'b0, 1'b0, '0},
        '{32'd4, 1'b1, 1'b0, '0},
        // max then min then small
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'd1, 1'b1, 1'b0, '0}
    };

    longest_increasing_subsequence_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sink backpressure
    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Append one element to the expected queue
    function automatic void queue_elem(input t_elem e);
        pending_elems = {pending_elems, e};
    endfunction

    // Patience update for one accepted sample; on the final one, queue a typed
    // expectation, else trace the longest run and queue it in input order.
    task automatic lis_absorb(input logic [31:0] raw, input logic fin,
                              input logic use_want, input t_elem want);
        int lo;
        int hi;
        int mid;
        int p;
        t_elem e;
        logic signed [31:0] v;
        v = raw;
        if (n_seen < DEPTH) begin
            lo = 0;
            hi = run_len;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (tail_vals[mid] < v)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            seen_vals[n_seen] = v;
            tail_vals[lo] = v;
            tail_idx[lo] = lis_pkg::POS_W'(n_seen);
            back_link[n_seen] = (lo > 0) ? lis_pkg::PRED_W'(tail_idx[lo-1])
                                         : lis_pkg::NO_PRED;
            if (lo == run_len)
                run_len++;
            n_seen++;
        end else begin
            spilled = 1'b1;
        end
        if (!fin)
            return;
        runs_sent++;
        if (spilled)
            spill_runs++;
        if (use_want) begin
            queue_elem(want);
        end else if (run_len > 0) begin
            p = tail_idx[run_len-1];
            for (int k = run_len; k > 0; k--) begin
                trace_path[k-1] = lis_pkg::POS_W'(p);
                p = back_link[p];
                if (p == lis_pkg::NO_PRED)
                    p = 0;
            end
            for (int k = 0; k < run_len; k++) begin
                e.value = seen_vals[trace_path[k]];
                e.pos   = trace_path[k];
                e.len   = lis_pkg::LEN_W'(run_len);
                e.ovf   = spilled;
                e.eor   = (k + 1 == run_len);
                queue_elem(e);
            end
        end
        run_len = 0;
        n_seen  = 0;
        spilled = 1'b0;
    endtask

    // Drive one sample; returns after its transfer, at the next falling edge
    task automatic send_sample(input logic [31:0] sample, input logic fin,
                               input logic use_want, input t_elem want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= sample;
        s_last  <= fin;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        lis_absorb(sample, fin, use_want, want);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(t_value_pat pat, int prev);
        case (pat)
            PAT_WIDE:   return $urandom;
            PAT_NARROW: return 32'(int'($urandom_range(16)) - 8);
            PAT_RISING: begin
                if ($urandom_range(7) == 0)
                    return 32'(prev - int'($urandom_range(500)));
                return 32'(prev + int'($urandom_range(1000, 1)));
            end
            default: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0000;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Compare each result transfer with the oldest queued element
    always @(posedge i_clk) begin : result_check
        t_elem want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_elems.size() == 0) begin
                $error("result transfer with nothing expected: tdata=%h tlast=%b",
                       m_data, m_last);
                err_count++;
            end else begin
                want = pending_elems.pop_front();
                elems_seen++;
                if (m_data[lis_pkg::OUT_POS_LSB-1:lis_pkg::OUT_VAL_LSB] !== want.value) begin
                    $error("elem_value: expected %h, got %h", want.value,
                           m_data[lis_pkg::OUT_POS_LSB-1:lis_pkg::OUT_VAL_LSB]);
                    err_count++;
                end
                if (m_data[lis_pkg::OUT_LEN_LSB-1:lis_pkg::OUT_POS_LSB] !== want.pos) begin
                    $error("elem_position: expected %0d, got %0d", want.pos,
                           m_data[lis_pkg::OUT_LEN_LSB-1:lis_pkg::OUT_POS_LSB]);
                    err_count++;
                end
                if (m_data[lis_pkg::OUT_OVF_BIT-1:lis_pkg::OUT_LEN_LSB] !== want.len) begin
                    $error("seq_length: expected %0d, got %0d", want.len,
                           m_data[lis_pkg::OUT_OVF_BIT-1:lis_pkg::OUT_LEN_LSB]);
                    err_count++;
                end
                if (m_data[lis_pkg::OUT_OVF_BIT] !== want.ovf) begin
                    $error("overflow_flag: expected %b, got %b", want.ovf,
                           m_data[lis_pkg::OUT_OVF_BIT]);
                    err_count++;
                end
                if (m_last !== want.eor) begin
                    $error("end_of_run: expected %b, got %b", want.eor, m_last);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int seq_len;
        int seq_idx;
        int prev;
        int phase;
        t_value_pat pat;
        logic [31:0] v;

        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_last  = 1'b0;
        m_ready = 1'b0;
        src_idle_pct = 11;
        dst_idle_pct = 66;
        err_count   = 0;
        cycle_count = 0;
        items_sent  = 0;
        elems_seen  = 0;
        runs_sent   = 0;
        spill_runs  = 0;
        run_len = 0;
        n_seen  = 0;
        spilled = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table
        foreach (dir_rows[r])
            send_sample(dir_rows[r].sample, dir_rows[r].fin, dir_rows[r].typed,
                        dir_rows[r].want);

        // Random sequences, three idle phases
        seq_idx = 0;
        while (items_sent - DIR_ROWS < RAND_ITEMS) begin
            phase = (items_sent - DIR_ROWS) * 3 / RAND_ITEMS;
            src_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 66 : 0;
            dst_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 11 : 0;

            // a capacity overrun and an exactly-full run come early
            if (seq_idx == 1) begin
                seq_len = DEPTH + 6;
                pat = PAT_RISING;
            end else if (seq_idx == 3) begin
                seq_len = DEPTH;
                pat = PAT_RISING;
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5, 6: seq_len = $urandom_range(10, 1);
                    7:                   seq_len = $urandom_range(40, 11);
                    8:                   seq_len = $urandom_range(DEPTH, DEPTH - 1);
                    default:             seq_len = $urandom_range(DEPTH + 8, DEPTH + 1);
                endcase
                pat = t_value_pat'($urandom_range(3));
            end

            prev = int'($urandom_range(1 << 20)) - (1 << 19);
            for (int i = 0; i < seq_len; i++) begin
                v = pick_value(pat, prev);
                prev = int'(v);
                send_sample(v, (i == seq_len - 1), 1'b0, '0);
            end
            seq_idx++;
        end
        s_valid <= 1'b0;
        s_last  <= 1'b0;

        while (pending_elems.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_elems.size() != 0) begin
            $error("%0d expected elements never arrived", pending_elems.size());
            err_count++;
        end

        $display("%0d samples in %0d sequences (%0d past capacity), %0d elements checked",
                 items_sent, runs_sent, spill_runs, elems_seen);
        $display("idle mixes: sender light/sink heavy, sender heavy/sink light, none");
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[longest_increasing_subsequence_top.f]
+incdir+rtl
rtl/lis_pkg.sv
rtl/lis_ctrl.sv
rtl/lis_datapath.sv
rtl/longest_increasing_subsequence_top.sv
tb/longest_increasing_subsequence_top_tb.sv
